// ----- src/rfid_ascii_frame_parser_defines.svh -----
// Assertion macros used by the checker file of the card frame parser.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef RFID_ASCII_FRAME_PARSER_DEFINES_SVH
`define RFID_ASCII_FRAME_PARSER_DEFINES_SVH

// Check on every rising edge outside reset.
`define RAFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define RAFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/rafp_pkg.sv -----
// Shared constants and the character decode for the card frame parser.
// No dependencies; used by the parser and its port checker.
package rafp_pkg;

	localparam int FRAME_CHARS = 12;
	localparam int ID_CHARS    = FRAME_CHARS - 2;
	localparam int ID_W        = 4 * ID_CHARS;

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UE    = 8'h45;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [3:0] NIB_BAD    = 4'hF;
	localparam logic [3:0] NIB_A      = 4'hA;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD_END = 2'd1;
	localparam status_t ST_ZEROS   = 2'd2;
	localparam status_t ST_CHECK   = 2'd3;

	// Map one ASCII hex character to its nibble; anything else reads as 0xF.
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		logic [3:0] nib;
		d   = 8'h00;
		nib = NIB_BAD;
		if (c inside {[CHAR_0:CHAR_9]}) begin
			d   = c - CHAR_0;
			nib = d[3:0];
		end else if (c inside {[CHAR_UA:CHAR_UE]}) begin
			d   = c - CHAR_UA;
			nib = d[3:0] + NIB_A;
		end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
			d   = c - CHAR_LA;
			nib = d[3:0] + NIB_A;
		end
		return nib;
	endfunction

endpackage

// ----- src/rfid_ascii_frame_parser.sv -----
// Card reader frame parser: start byte, twelve hex characters, end byte.
// Depends on rafp_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------
//  rx      | rx_valid/rx_ready  | rx_byte[7:0]
//  res     | res_valid/res_ready| frame_status[1:0], card_id[39:0]
//
// One byte is taken per cycle while rx_ready is high; frame state is registered as each byte is taken.
// The byte in the end slot loads the result register; the result appears
// on the following cycle. rx_ready drops only while a result waits and
// res_ready is low. Reset clears the phase and the result valid flag.
module rfid_ascii_frame_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rx_valid,
	output logic                      rx_ready,
	input  logic [7:0]                rx_byte,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [1:0]                frame_status,
	output logic [rafp_pkg::ID_W-1:0] card_id
);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_CHARS = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;

	localparam logic [3:0] ID_CNT    = 4'(rafp_pkg::ID_CHARS);
	localparam logic [3:0] FRAME_CNT = 4'(rafp_pkg::FRAME_CHARS);

	logic [1:0]                phase_q;
	logic [3:0]                count_q;
	logic [rafp_pkg::ID_W-1:0] id_q;
	logic [7:0]                xor_q;
	logic [7:0]                check_q;
	logic [3:0]                high_q;
	logic                      zeros_q;

	logic                      res_valid_q;
	rafp_pkg::status_t         status_q;
	logic [rafp_pkg::ID_W-1:0] card_id_q;

	logic                      rx_fire;
	logic [3:0]                nib;
	logic [7:0]                pair;
	logic [3:0]                count_nx;
	rafp_pkg::status_t         status_nx;

	assign rx_ready = !res_valid_q || res_ready;
	assign rx_fire  = rx_valid && rx_ready;
	assign nib      = rafp_pkg::nibble_of(rx_byte);
	assign pair     = {high_q, nib};
	assign count_nx = count_q + 4'd1;

	always_comb begin
		if (rx_byte != rafp_pkg::END_BYTE) begin
			status_nx = rafp_pkg::ST_BAD_END;
		end else if (zeros_q) begin
			status_nx = rafp_pkg::ST_ZEROS;
		end else if (check_q != xor_q) begin
			status_nx = rafp_pkg::ST_CHECK;
		end else begin
			status_nx = rafp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 4'd0;
			id_q    <= '0;
			xor_q   <= 8'h00;
			check_q <= 8'h00;
			high_q  <= 4'h0;
			zeros_q <= 1'b1;
		end else if (rx_fire) begin
			case (phase_q)
				PH_CHARS: begin
					zeros_q <= zeros_q && (rx_byte == rafp_pkg::CHAR_0);
					if (count_q < ID_CNT) begin
						id_q <= {id_q[rafp_pkg::ID_W-5:0], nib};
					end
					if (!count_q[0]) begin
						high_q <= nib;
					end else if (count_q < ID_CNT) begin
						xor_q <= xor_q ^ pair;
					end else begin
						check_q <= pair;
					end
					count_q <= count_nx;
					if (count_nx >= FRAME_CNT) begin
						phase_q <= PH_END;
					end
				end
				PH_END: begin
					// result goes out; drop frame state either way
					phase_q <= PH_HUNT;
					count_q <= 4'd0;
					id_q    <= '0;
					xor_q   <= 8'h00;
					check_q <= 8'h00;
					high_q  <= 4'h0;
					zeros_q <= 1'b1;
				end
				default: begin
					if (rx_byte == rafp_pkg::START_BYTE) begin
						phase_q <= PH_CHARS;
						count_q <= 4'd0;
						id_q    <= '0;
						xor_q   <= 8'h00;
						check_q <= 8'h00;
						high_q  <= 4'h0;
						zeros_q <= 1'b1;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_fire && phase_q == PH_END) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_END) begin
			status_q  <= status_nx;
			card_id_q <= (status_nx == rafp_pkg::ST_OK) ? id_q : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign card_id      = card_id_q;

endmodule

// ----- src/rafp_checker.sv -----
// Port-level checks for the card frame parser, bound to its top level.
// Depends on rafp_pkg and rfid_ascii_frame_parser_defines.svh.
`include "rfid_ascii_frame_parser_defines.svh"

module rafp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rx_valid,
	input logic                      rx_ready,
	input logic [7:0]                rx_byte,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [1:0]                frame_status,
	input logic [rafp_pkg::ID_W-1:0] card_id
);

	logic                        rx_stall;
	logic                        res_stall;
	logic                        res_bad;
	logic [rafp_pkg::ID_W+1:0]   res_word;

	assign rx_stall  = rx_valid && !rx_ready;
	assign res_stall = res_valid && !res_ready;
	assign res_bad   = res_valid && (frame_status != rafp_pkg::ST_OK);
	assign res_word  = {frame_status, card_id};

	`RAFP_ASSERT(a_rx_hold, rx_stall |=> rx_valid && $stable(rx_byte), "input word moved in stall")
	`RAFP_ASSERT(a_res_hold, res_stall |=> res_valid && $stable(res_word), "result moved in stall")
	`RAFP_ASSERT(a_id_zero, res_bad |-> card_id == '0, "nonzero id on failed frame")
	`RAFP_ASSERT(a_ready_stall, !rx_ready |-> res_stall, "input stalled without a waiting result")
	`RAFP_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind rfid_ascii_frame_parser rafp_checker u_rafp_checker (.*);
